// ===== hdl/lru_page_frame_replacer_assert.svh =====
// Assertion macros for the LRU page frame replacer.
// Expects clk and rst in the scope that uses them.
`ifndef LRU_PAGE_FRAME_REPLACER_ASSERT_SVH
`define LRU_PAGE_FRAME_REPLACER_ASSERT_SVH

// same-cycle implication
`define LPFR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LPFR_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/lpfr_pkg.sv =====
// Shared constants for the LRU page frame replacer.
// No dependencies; used by the channel interfaces and the top level.
`default_nettype none

package lpfr_pkg;

  localparam int ADDR_W        = 31;  // access_address field
  localparam int FRAME_FIELD_W = 6;   // frame_index field
  localparam int PAGE_FIELD_W  = 19;  // page_number and evicted_page fields

endpackage

`default_nettype wire

// ===== hdl/lpfr_channel_if.sv =====
// Valid/ready channel interfaces of the LRU page frame replacer.
// Depends on lpfr_pkg for the field widths.
`default_nettype none

interface lpfr_access_if;
  import lpfr_pkg::*;

  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] access_address;

  modport source (output valid, output access_address, input ready);
  modport sink   (input valid, input access_address, output ready);
endinterface

interface lpfr_result_if;
  import lpfr_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [FRAME_FIELD_W-1:0] frame_index;
  logic                     was_hit;
  logic [PAGE_FIELD_W-1:0]  page_number;
  logic                     evicted_valid;
  logic [PAGE_FIELD_W-1:0]  evicted_page;

  modport source (output valid, output frame_index, output was_hit, output page_number,
                  output evicted_valid, output evicted_page, input ready);
  modport sink   (input valid, input frame_index, input was_hit, input page_number,
                  input evicted_valid, input evicted_page, output ready);
endinterface

`default_nettype wire

// ===== hdl/lru_page_frame_replacer.sv =====
// LRU page frame replacer.
// Access channel (sink): one transaction per memory access, carrying access_address.
// Result channel (source): one transaction per access with frame, hit flag, page and
// evicted page.
// After reset the page map is swept clear, one entry per cycle, over all
// 2**PAGE_NUMBER_BITS entries (524288 at the defaults); access.ready stays low then.
// Per access, the states from acceptance back to S_IDLE:
//   hit on the most recent frame: S_LOOKUP, S_DONE
//   miss while free frames remain: S_LOOKUP, S_FILL2, S_DONE
//   miss with eviction: S_LOOKUP, S_LINK, S_W2, S_DONE
//   hit on the least recent frame: S_LOOKUP, S_LINK, S_W2, S_DONE
//   any other hit: S_LOOKUP, S_LINK, S_W2, S_W3, S_DONE
// The state sequence is set by the single write port of each link memory: an LRU reorder
// rewrites up to three newer links, one per cycle.
// The result sits in an output register; the next access is taken while it waits.
// A stalled result only holds the sequencer in its final state until the register
// frees up.
// Depends on lpfr_pkg, lpfr_channel_if and lru_page_frame_replacer_assert.svh.
`default_nettype none

`include "lru_page_frame_replacer_assert.svh"

module lru_page_frame_replacer #(
  parameter int FRAMES           = 64,
  parameter int PAGE_SHIFT       = 12,
  parameter int PAGE_NUMBER_BITS = 19
) (
  input  wire logic     clk,
  input  wire logic     rst,
  lpfr_access_if.sink   access,
  lpfr_result_if.source result
);
  import lpfr_pkg::*;

  localparam int FRAME_W = $clog2(FRAMES);
  localparam int LINK_W  = $clog2(FRAMES + 1);
  localparam int PNB     = PAGE_NUMBER_BITS;
  localparam int WIDE_W  = ADDR_W + PNB;
  localparam int PAGES   = 1 << PNB;
  localparam logic [LINK_W-1:0] NO_FRAME = LINK_W'(FRAMES);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_LOOKUP, S_LINK, S_W2, S_W3, S_FILL2, S_DONE
  } state_t;

  state_t state;

  // memories
  logic [LINK_W-1:0]  map_mem   [PAGES];
  logic [PNB-1:0]     fpage_mem [FRAMES];
  logic [LINK_W-1:0]  newer_mem [FRAMES];
  logic [LINK_W-1:0]  older_mem [FRAMES];

  logic [LINK_W-1:0]  map_rd;
  logic [PNB-1:0]     fpage_rd;
  logic [LINK_W-1:0]  newer_rd;
  logic [LINK_W-1:0]  older_rd;

  // sequencer registers
  logic [PNB-1:0]     clr_cnt;
  logic [PNB-1:0]     page;
  logic [FRAME_W-1:0] frame;
  logic               hit;
  logic               evict;
  logic [PNB-1:0]     ev_page;
  logic [FRAME_W-1:0] most_recent;
  logic [FRAME_W-1:0] least_recent;
  logic [LINK_W-1:0]  frames_used;

  // output register
  logic                     out_valid;
  logic [FRAME_FIELD_W-1:0] out_frame;
  logic                     out_hit;
  logic [PAGE_FIELD_W-1:0]  out_page;
  logic                     out_ev_valid;
  logic [PAGE_FIELD_W-1:0]  out_ev_page;

  // page number of the incoming address
  logic [WIDE_W-1:0] addr_wide;
  logic [WIDE_W-1:0] addr_shifted;
  logic [PNB-1:0]    in_page;

  assign addr_wide    = WIDE_W'(access.access_address);
  assign addr_shifted = addr_wide >> PAGE_SHIFT;
  assign in_page      = addr_shifted[PNB-1:0];

  // lookup decode
  logic [LINK_W-1:0]  entry_dec;
  logic               map_hit;
  logic               full;
  logic [FRAME_W-1:0] frame_sel;

  assign entry_dec = map_rd - LINK_W'(1);
  assign map_hit   = (map_rd != '0);
  assign full      = (frames_used == NO_FRAME);

  always_comb begin
    frame_sel = frame;
    if (state == S_LOOKUP) begin
      if (map_hit) begin
        frame_sel = entry_dec[FRAME_W-1:0];
      end else if (full) begin
        frame_sel = least_recent;
      end else begin
        frame_sel = frames_used[FRAME_W-1:0];
      end
    end
  end

  // memory write ports
  logic               map_we;
  logic [PNB-1:0]     map_waddr;
  logic [LINK_W-1:0]  map_wdata;
  logic               fp_we;
  logic               nl_we;
  logic [FRAME_W-1:0] nl_waddr;
  logic [LINK_W-1:0]  nl_wdata;
  logic               ol_we;
  logic [FRAME_W-1:0] ol_waddr;
  logic [LINK_W-1:0]  ol_wdata;
  logic [LINK_W-1:0]  frame_plus1;

  assign frame_plus1 = LINK_W'(frame_sel) + LINK_W'(1);

  always_comb begin
    map_we    = 1'b0;
    map_waddr = page;
    map_wdata = frame_plus1;
    fp_we     = 1'b0;
    nl_we     = 1'b0;
    nl_waddr  = frame_sel;
    nl_wdata  = NO_FRAME;
    ol_we     = 1'b0;
    ol_waddr  = frame_sel;
    ol_wdata  = NO_FRAME;
    case (state)
      S_CLEAR: begin
        map_we    = 1'b1;
        map_waddr = clr_cnt;
        map_wdata = '0;
      end
      S_LOOKUP: begin
        if (!map_hit && !full) begin
          map_we = 1'b1;
          fp_we  = 1'b1;
          ol_we  = 1'b1;
          nl_we  = 1'b1;
          if (frames_used != '0) begin
            ol_wdata = LINK_W'(most_recent);
            nl_waddr = most_recent;
            nl_wdata = LINK_W'(frame_sel);
          end
        end
      end
      S_LINK: begin
        // unlink: older of the next newer frame skips over this one
        ol_we    = 1'b1;
        ol_waddr = newer_rd[FRAME_W-1:0];
        ol_wdata = older_rd;
        nl_we    = 1'b1;
        if (evict) begin
          map_we    = 1'b1;
          map_waddr = fpage_rd;
          map_wdata = '0;
        end
      end
      S_W2: begin
        ol_we    = 1'b1;
        ol_wdata = LINK_W'(most_recent);
        nl_we    = 1'b1;
        nl_waddr = most_recent;
        nl_wdata = LINK_W'(frame);
        if (evict) begin
          map_we = 1'b1;
          fp_we  = 1'b1;
        end
      end
      S_W3: begin
        nl_we    = 1'b1;
        nl_waddr = older_rd[FRAME_W-1:0];
        nl_wdata = newer_rd;
      end
      S_FILL2: begin
        nl_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[map_waddr] <= map_wdata;
    end
    if (state == S_IDLE) begin
      map_rd <= map_mem[in_page];
    end
  end

  always_ff @(posedge clk) begin
    if (fp_we) begin
      fpage_mem[frame_sel] <= page;
    end
    if (nl_we) begin
      newer_mem[nl_waddr] <= nl_wdata;
    end
    if (ol_we) begin
      older_mem[ol_waddr] <= ol_wdata;
    end
    // link reads are taken once per access and held for the reorder
    if (state == S_LOOKUP) begin
      fpage_rd <= fpage_mem[frame_sel];
      newer_rd <= newer_mem[frame_sel];
      older_rd <= older_mem[frame_sel];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_cnt     <= '0;
      frames_used <= '0;
      out_valid   <= 1'b0;
    end else begin
      // S_DONE reloads the register itself
      if (out_valid && result.ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + PNB'(1);
          if (&clr_cnt) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (access.valid) begin
            page  <= in_page;
            state <= S_LOOKUP;
          end
        end
        S_LOOKUP: begin
          frame <= frame_sel;
          hit   <= map_hit;
          evict <= !map_hit && full;
          if (map_hit) begin
            state <= (frame_sel == most_recent) ? S_DONE : S_LINK;
          end else if (full) begin
            state <= S_LINK;
          end else begin
            state <= S_FILL2;
          end
        end
        S_LINK: begin
          ev_page <= fpage_rd;
          if (older_rd == NO_FRAME) begin
            least_recent <= newer_rd[FRAME_W-1:0];
          end
          state <= S_W2;
        end
        S_W2: begin
          most_recent <= frame;
          state       <= (older_rd == NO_FRAME) ? S_DONE : S_W3;
        end
        S_W3: begin
          state <= S_DONE;
        end
        S_FILL2: begin
          most_recent <= frame;
          if (frames_used == '0) begin
            least_recent <= frame;
          end
          frames_used <= frames_used + LINK_W'(1);
          state       <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || result.ready) begin
            out_valid    <= 1'b1;
            out_frame    <= FRAME_FIELD_W'(frame);
            out_hit      <= hit;
            out_page     <= PAGE_FIELD_W'(page);
            out_ev_valid <= evict;
            out_ev_page  <= evict ? PAGE_FIELD_W'(ev_page) : '0;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign access.ready         = (state == S_IDLE);
  assign result.valid         = out_valid;
  assign result.frame_index   = out_frame;
  assign result.was_hit       = out_hit;
  assign result.page_number   = out_page;
  assign result.evicted_valid = out_ev_valid;
  assign result.evicted_page  = out_ev_page;

  `LPFR_ASSERT_IMP(a_evict_only_when_full, result.valid && result.evicted_valid, !result.was_hit && frames_used == NO_FRAME, "eviction reported before all frames were used")
  `LPFR_ASSERT_NXT(a_accept_to_lookup, access.valid && access.ready, state == S_LOOKUP, "accepted transaction did not start a lookup")
  `LPFR_ASSERT_NXT(a_fill_counts_one, state == S_FILL2, frames_used == LINK_W'($past(frames_used) + LINK_W'(1)), "frame fill did not advance the used count by one")

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for lru_page_frame_replacer: a queue-fed access driver, a result
// monitor and an LRU page-placement predictor that models the frame map and recency order.
// Depends on lpfr_pkg, the lpfr channel interfaces and the replacer RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lpfr_pkg::*;

  localparam int FRAMES         = 64;
  localparam int PAGE_SHIFT     = 12;
  localparam int PAGE_BITS      = 19;
  localparam int NO_FRAME       = FRAMES;
  localparam int RANDOM_ITEMS   = 630;
  localparam int POOL_SIZE      = 96;
  // the map sweep after reset alone clears all 2**PAGE_BITS entries with no transaction
  localparam int WATCHDOG_LIMIT = 4 * (1 << PAGE_BITS);
  localparam int DRAIN_CYCLES   = 32;
  localparam int MAX_REPORTS    = 40;

  typedef struct packed {
    logic [FRAME_FIELD_W-1:0] frame;
    logic                     hit;
    logic [PAGE_FIELD_W-1:0]  page;
    logic                     evicted;
    logic [PAGE_FIELD_W-1:0]  evicted_page;
  } placement_t;

  logic clk;
  logic rst;

  lpfr_access_if acc_if ();
  lpfr_result_if res_if ();

  lru_page_frame_replacer #(
    .FRAMES          (FRAMES),
    .PAGE_SHIFT      (PAGE_SHIFT),
    .PAGE_NUMBER_BITS(PAGE_BITS)
  ) u_top (
    .clk   (clk),
    .rst   (rst),
    .access(acc_if),
    .result(res_if)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // predictor state: page -> frame, frame -> page, and the recency order as a linked list
  int unsigned             frame_of_page [int unsigned];
  logic [PAGE_FIELD_W-1:0] page_in_frame [FRAMES];
  int                      newer_of [FRAMES];
  int                      older_of [FRAMES];
  int                      mru_frame     = 0;
  int                      lru_frame     = 0;
  int                      frames_in_use = 0;

  logic [ADDR_W-1:0] access_q [$];
  placement_t        placement_q [$];

  int total_items    = 0;
  int accepted_count = 0;
  int result_count   = 0;
  int fail_count     = 0;
  int send_wait      = 0;
  int recv_wait      = 0;
  int idle_cycles    = 0;
  logic send_steady  = 1'b0;
  logic recv_steady  = 1'b0;

  function automatic void make_newest(int f);
    if (mru_frame < FRAMES) newer_of[mru_frame] = f;
    older_of[f] = mru_frame;
    newer_of[f] = NO_FRAME;
    mru_frame   = f;
  endfunction

  function automatic void touch_frame(int f);
    int o;
    int n;
    if (f == mru_frame) return;
    o = older_of[f];
    n = newer_of[f];
    if (n < FRAMES) older_of[n] = o;
    if (o < FRAMES) newer_of[o] = n;
    else lru_frame = n;
    make_newest(f);
  endfunction

  function automatic placement_t place_page(logic [ADDR_W-1:0] addr);
    placement_t              r;
    int                      f;
    logic [PAGE_FIELD_W-1:0] page;
    page   = PAGE_FIELD_W'(addr >> PAGE_SHIFT);
    r      = '0;
    r.page = page;
    if (frame_of_page.exists(page)) begin
      f     = frame_of_page[page];
      r.hit = 1'b1;
      touch_frame(f);
    end else if (frames_in_use < FRAMES) begin
      f                = frames_in_use;
      page_in_frame[f] = page;
      if (frames_in_use == 0) begin
        mru_frame   = f;
        lru_frame   = f;
        newer_of[f] = NO_FRAME;
        older_of[f] = NO_FRAME;
      end else begin
        make_newest(f);
      end
      frame_of_page[page] = f;
      frames_in_use++;
    end else begin
      f              = lru_frame;
      r.evicted      = 1'b1;
      r.evicted_page = page_in_frame[f];
      frame_of_page.delete(page_in_frame[f]);
      frame_of_page[page] = f;
      page_in_frame[f]    = page;
      touch_frame(f);
    end
    r.frame = FRAME_FIELD_W'(f);
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] mk_address(logic [PAGE_FIELD_W-1:0] page,
                                                   logic [PAGE_SHIFT-1:0] offset);
    return {page, offset};
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    fail_count++;
    if (fail_count <= MAX_REPORTS)
      $display("result %0d: %s is 0x%0h, expected 0x%0h", result_count, what, got, want);
  endtask

  // access driver
  always @(posedge clk) begin : drive_access
    logic              next_valid;
    logic [ADDR_W-1:0] next_addr;
    if (rst) begin
      acc_if.valid          <= 1'b0;
      acc_if.access_address <= '0;
      send_wait = 0;
    end else begin
      next_valid = acc_if.valid;
      next_addr  = acc_if.access_address;
      if (acc_if.valid && acc_if.ready) begin
        placement_q.push_back(place_page(acc_if.access_address));
        accepted_count++;
        next_valid = 1'b0;
        if ($urandom_range(0, 39) == 0) send_steady = ~send_steady;
        send_wait = send_steady ? 0 : $urandom_range(0, 6);
      end
      if (!next_valid) begin
        if (send_wait > 0) begin
          send_wait--;
        end else if (access_q.size() > 0) begin
          next_valid = 1'b1;
          next_addr  = access_q.pop_front();
        end
      end
      acc_if.valid          <= next_valid;
      acc_if.access_address <= next_addr;
    end
  end

  // result monitor and checker
  always @(posedge clk) begin : watch_result
    logic       next_ready;
    placement_t want;
    if (rst) begin
      res_if.ready <= 1'b0;
      recv_wait = 0;
    end else begin
      next_ready = res_if.ready;
      if (res_if.valid && res_if.ready) begin
        result_count++;
        if (placement_q.size() == 0) begin
          report_mismatch("unrequested transaction, frame_index", res_if.frame_index, 0);
        end else begin
          want = placement_q.pop_front();
          if (res_if.frame_index !== want.frame)
            report_mismatch("frame_index", res_if.frame_index, want.frame);
          if (res_if.was_hit !== want.hit)
            report_mismatch("was_hit", res_if.was_hit, want.hit);
          if (res_if.page_number !== want.page)
            report_mismatch("page_number", res_if.page_number, want.page);
          if (res_if.evicted_valid !== want.evicted)
            report_mismatch("evicted_valid", res_if.evicted_valid, want.evicted);
          if (res_if.evicted_page !== want.evicted_page)
            report_mismatch("evicted_page", res_if.evicted_page, want.evicted_page);
        end
        if ($urandom_range(0, 39) == 0) recv_steady = ~recv_steady;
        recv_wait  = recv_steady ? 0 : $urandom_range(0, 6);
        next_ready = (recv_wait == 0);
      end else if (!res_if.ready) begin
        if (recv_wait > 0) recv_wait--;
        next_ready = (recv_wait == 0);
      end
      res_if.ready <= next_ready;
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((acc_if.valid && acc_if.ready) || (res_if.valid && res_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [PAGE_FIELD_W-1:0] pool [POOL_SIZE];
    logic [PAGE_FIELD_W-1:0] page;
    logic [PAGE_FIELD_W-1:0] last_page;
    int                      sel;

    rst                   = 1'b1;
    acc_if.valid          = 1'b0;
    acc_if.access_address = '0;
    res_if.ready          = 1'b0;

    // directed: field extremes, first frame, hit on newest, oldest and middle frames
    access_q.push_back(31'h0000_0000);
    access_q.push_back(31'h0000_0FFF);
    access_q.push_back(31'h7FFF_FFFF);
    access_q.push_back(31'h7FFF_F000);
    access_q.push_back(31'h0000_0123);
    access_q.push_back(mk_address(19'd1, 12'hABC));
    access_q.push_back(mk_address(19'd2, 12'h000));
    access_q.push_back(mk_address(19'd3, 12'hFFF));
    access_q.push_back(mk_address(19'h7FFFF, 12'h555));
    access_q.push_back(mk_address(19'd2, 12'hAAA));
    access_q.push_back(mk_address(19'd2, 12'h001));
    access_q.push_back(mk_address(19'd3, 12'h800));
    access_q.push_back(mk_address(19'd0, 12'h7FF));
    access_q.push_back(mk_address(19'h55555, 12'hAAA));
    access_q.push_back(mk_address(19'h2AAAA, 12'h555));
    access_q.push_back(mk_address(19'd1, 12'h000));

    // random: mostly a working set somewhat larger than the frame count, so the
    // frames fill and then hits and evictions mix; some repeats and cold pages
    foreach (pool[i]) pool[i] = PAGE_FIELD_W'($urandom);
    pool[0]   = '0;
    pool[1]   = '1;
    last_page = '0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      sel = $urandom_range(0, 99);
      if (sel < 12) page = last_page;
      else if (sel < 22) page = PAGE_FIELD_W'($urandom);
      else page = pool[$urandom_range(0, POOL_SIZE - 1)];
      access_q.push_back(mk_address(page, PAGE_SHIFT'($urandom)));
      last_page = page;
    end
    total_items = access_q.size();

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (accepted_count < total_items || placement_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
